FILE: rtl/ctlf_pkg.sv
package ctlf_pkg;

  // Payload widths
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int ID_W     = 4;
  localparam int STATUS_W = 3;

  // Default table depth
  localparam int MAX_PEERS_DEF = 16;

  // Command codes
  localparam logic CMD_LEARN = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_EXISTING = 3'd0,
    ST_ADDED    = 3'd1,
    ST_FULL     = 3'd2,
    ST_FREED    = 3'd3,
    ST_UNUSED   = 3'd4
  } status_t;

endpackage

FILE: rtl/ctlf_if.sv
interface ctlf_req_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [ctlf_pkg::ADDR_W-1:0] src_addr;
  logic [ctlf_pkg::PORT_W-1:0] src_port;
  logic [ctlf_pkg::ID_W-1:0]   free_id;

  modport source (output valid, cmd, src_addr, src_port, free_id, input ready);
  modport sink (input valid, cmd, src_addr, src_port, free_id, output ready);
endinterface

interface ctlf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ctlf_pkg::ID_W-1:0]     conn_id;
  logic [ctlf_pkg::STATUS_W-1:0] status;

  modport source (output valid, conn_id, status, input ready);
  modport sink (input valid, conn_id, status, output ready);
endinterface

FILE: rtl/ctlf_entry_mem.sv
module ctlf_entry_mem #(
  parameter int MAX_PEERS = ctlf_pkg::MAX_PEERS_DEF,
  parameter int IW        = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [IW-1:0]               wr_idx,
  input  logic [ctlf_pkg::ADDR_W-1:0] wr_addr,
  input  logic [ctlf_pkg::PORT_W-1:0] wr_port,
  input  logic [IW-1:0]               wr_owner,
  input  logic                        rd_en,
  input  logic [IW-1:0]               rd_idx,
  output logic [ctlf_pkg::ADDR_W-1:0] rd_addr,
  output logic [ctlf_pkg::PORT_W-1:0] rd_port,
  output logic [IW-1:0]               rd_owner
);

  logic [ctlf_pkg::ADDR_W-1:0] mem_addr  [MAX_PEERS];
  logic [ctlf_pkg::PORT_W-1:0] mem_port  [MAX_PEERS];
  logic [IW-1:0]               mem_owner [MAX_PEERS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_addr[wr_idx]  <= wr_addr;
      mem_port[wr_idx]  <= wr_port;
      mem_owner[wr_idx] <= wr_owner;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr  <= mem_addr[rd_idx];
      rd_port  <= mem_port[rd_idx];
      rd_owner <= mem_owner[rd_idx];
    end
  end

endmodule

FILE: rtl/ctlf_id_map.sv
module ctlf_id_map #(
  parameter int MAX_PEERS = ctlf_pkg::MAX_PEERS_DEF,
  parameter int IW        = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [IW-1:0]        rd_idx,
  output logic [IW-1:0]        rd_slot,
  input  logic                 wr_en,
  input  logic [IW-1:0]        wr_idx,
  input  logic [IW-1:0]        wr_slot,
  input  logic                 vld_set,
  input  logic                 vld_clr,
  input  logic [IW-1:0]        vld_idx,
  output logic [MAX_PEERS-1:0] id_valid
);

  logic [IW-1:0] slot_mem [MAX_PEERS];

  // Slot memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_idx] <= wr_slot;
    end
    if (rd_en) begin
      rd_slot <= slot_mem[rd_idx];
    end
  end

  // Mark ids used or unused; all unused at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      id_valid <= '0;
    end else if (vld_set) begin
      id_valid[vld_idx] <= 1'b1;
    end else if (vld_clr) begin
      id_valid[vld_idx] <= 1'b0;
    end
  end

endmodule

FILE: rtl/connection_table_learn_free.sv
// Connection table for peers keyed by IPv4 address and UDP port.
// Channel req carries one item: cmd (learn or free), src_addr, src_port and
// free_id. Channel rsp returns one item per request: conn_id and status.
// Both use valid/ready; an item moves when both are high at a clock edge.
// cfg_we/cfg_wdata write server_mode (1 learns peers, 0 maps learns to id 0).
// The block works on one request at a time. A server-mode learn walks every
// entry of the entry memory, one read per cycle, before it decides; a free
// reads the freed id's slot and then moves the last entry (slot read, move),
// and a client-mode learn or a free of an unused id goes straight to the result.
// The table lives in an entry memory (address, port, owner id) and an id map
// memory (slot per id), both with registered reads, plus one used bit per id.
// Reset (rst, synchronous) marks every id unused, empties the table and sets
// server_mode to 1; no clearing pass is needed.
// A finished result sits in an output register; the next request is accepted
// while it waits. If rsp stays stalled, the following result holds inside
// and req is not ready until the output register frees up.
module connection_table_learn_free #(
  parameter int MAX_PEERS = ctlf_pkg::MAX_PEERS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  ctlf_req_if.sink       req,
  ctlf_rsp_if.source     rsp
);

  localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int CW = $clog2(MAX_PEERS + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PEERS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_FMOVE  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state;
  logic   server_mode;
  logic [CW-1:0] count;

  // Held request
  logic [ctlf_pkg::ADDR_W-1:0] k_addr;
  logic [ctlf_pkg::PORT_W-1:0] k_port;
  logic [IW-1:0]               k_fid;
  logic [ctlf_pkg::ID_W-1:0]   k_fid_raw;

  // Scan state
  logic [CW-1:0] scan_i;
  logic          p_live;
  logic          found;
  logic [IW-1:0] found_id;
  logic          have_free;
  logic [IW-1:0] new_id;

  // Pending result and output register
  logic [ctlf_pkg::ID_W-1:0] res_id;
  ctlf_pkg::status_t         res_status;
  logic                      rsp_valid;
  logic [ctlf_pkg::ID_W-1:0] rsp_conn_id;
  ctlf_pkg::status_t         rsp_status;

  // Memory ports
  logic                        ent_wr_en;
  logic [IW-1:0]               ent_wr_idx;
  logic [ctlf_pkg::ADDR_W-1:0] ent_wr_addr;
  logic [ctlf_pkg::PORT_W-1:0] ent_wr_port;
  logic [IW-1:0]               ent_wr_owner;
  logic                        ent_rd_en;
  logic [IW-1:0]               ent_rd_idx;
  logic [ctlf_pkg::ADDR_W-1:0] ent_rd_addr;
  logic [ctlf_pkg::PORT_W-1:0] ent_rd_port;
  logic [IW-1:0]               ent_rd_owner;

  logic                 map_rd_en;
  logic [IW-1:0]        map_rd_slot;
  logic                 map_wr_en;
  logic [IW-1:0]        map_wr_idx;
  logic [IW-1:0]        map_wr_slot;
  logic                 vld_set;
  logic                 vld_clr;
  logic [IW-1:0]        vld_idx;
  logic [MAX_PEERS-1:0] id_valid;

  logic          accept;
  logic          fid_ok;
  logic          scan_more;
  logic          hit;
  logic          add_ok;
  logic [IW-1:0] last;
  logic          do_move;

  assign accept    = req.valid && req.ready;
  assign fid_ok    = 32'(req.free_id) < MAX_PEERS;
  assign scan_more = scan_i != COUNT_MAX;
  assign hit       = p_live && (ent_rd_addr == k_addr) && (ent_rd_port == k_port);
  assign add_ok    = !found && have_free && (count < COUNT_MAX);
  assign last      = IW'(count - 1'b1);
  assign do_move   = map_rd_slot < last;

  assign req.ready   = state == S_IDLE;
  assign rsp.valid   = rsp_valid;
  assign rsp.conn_id = rsp_conn_id;
  assign rsp.status  = rsp_status;

  // Memory access steering
  always_comb begin
    ent_rd_en    = 1'b0;
    ent_rd_idx   = scan_i[IW-1:0];
    ent_wr_en    = 1'b0;
    ent_wr_idx   = IW'(count);
    ent_wr_addr  = k_addr;
    ent_wr_port  = k_port;
    ent_wr_owner = new_id;
    map_rd_en    = 1'b0;
    map_wr_en    = 1'b0;
    map_wr_idx   = new_id;
    map_wr_slot  = IW'(count);
    vld_set      = 1'b0;
    vld_clr      = 1'b0;
    vld_idx      = new_id;
    unique case (state)
      S_IDLE: begin
        // read the freed id's slot and the last entry together
        if (accept && req.cmd == ctlf_pkg::CMD_FREE) begin
          ent_rd_en  = 1'b1;
          ent_rd_idx = last;
          map_rd_en  = 1'b1;
        end
      end
      S_SCAN: begin
        ent_rd_en = scan_more;
      end
      S_DECIDE: begin
        // append new entry and point its id at it
        if (add_ok) begin
          ent_wr_en = 1'b1;
          map_wr_en = 1'b1;
          vld_set   = 1'b1;
        end
      end
      S_FMOVE: begin
        // move last entry into the freed slot
        ent_wr_idx   = map_rd_slot;
        ent_wr_addr  = ent_rd_addr;
        ent_wr_port  = ent_rd_port;
        ent_wr_owner = ent_rd_owner;
        map_wr_idx   = ent_rd_owner;
        map_wr_slot  = map_rd_slot;
        ent_wr_en    = do_move;
        map_wr_en    = do_move;
        vld_clr      = 1'b1;
        vld_idx      = k_fid;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      server_mode <= 1'b1;
    end else if (cfg_we) begin
      server_mode <= cfg_wdata;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // drop the taken result unless a new one is handed over
      if (rsp_valid && rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            k_addr    <= req.src_addr;
            k_port    <= req.src_port;
            k_fid     <= IW'(req.free_id);
            k_fid_raw <= req.free_id;
            scan_i    <= '0;
            p_live    <= 1'b0;
            found     <= 1'b0;
            have_free <= 1'b0;
            if (req.cmd == ctlf_pkg::CMD_LEARN) begin
              if (server_mode) begin
                state <= S_SCAN;
              end else begin
                res_id     <= '0;
                res_status <= ctlf_pkg::ST_EXISTING;
                state      <= S_DONE;
              end
            end else if (!fid_ok || !id_valid[IW'(req.free_id)] || count == '0) begin
              res_id     <= req.free_id;
              res_status <= ctlf_pkg::ST_UNUSED;
              state      <= S_DONE;
            end else begin
              state <= S_FMOVE;
            end
          end
        end
        S_SCAN: begin
          // compare the entry read last cycle; highest matching slot wins
          if (hit) begin
            found    <= 1'b1;
            found_id <= ent_rd_owner;
          end
          if (scan_more) begin
            p_live <= scan_i < count;
            if (!have_free && !id_valid[scan_i[IW-1:0]]) begin
              have_free <= 1'b1;
              new_id    <= scan_i[IW-1:0];
            end
            scan_i <= scan_i + 1'b1;
          end else begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          priority if (found) begin
            res_id     <= ctlf_pkg::ID_W'(found_id);
            res_status <= ctlf_pkg::ST_EXISTING;
          end else if (add_ok) begin
            count      <= count + 1'b1;
            res_id     <= ctlf_pkg::ID_W'(new_id);
            res_status <= ctlf_pkg::ST_ADDED;
          end else begin
            res_id     <= '0;
            res_status <= ctlf_pkg::ST_FULL;
          end
          state <= S_DONE;
        end
        S_FMOVE: begin
          count      <= count - 1'b1;
          res_id     <= k_fid_raw;
          res_status <= ctlf_pkg::ST_FREED;
          state      <= S_DONE;
        end
        S_DONE: begin
          // hand the result over once the output register is free
          if (!rsp_valid || rsp.ready) begin
            rsp_valid   <= 1'b1;
            rsp_conn_id <= res_id;
            rsp_status  <= res_status;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  ctlf_entry_mem #(
    .MAX_PEERS (MAX_PEERS),
    .IW        (IW)
  ) u_entry_mem (
    .clk      (clk),
    .wr_en    (ent_wr_en),
    .wr_idx   (ent_wr_idx),
    .wr_addr  (ent_wr_addr),
    .wr_port  (ent_wr_port),
    .wr_owner (ent_wr_owner),
    .rd_en    (ent_rd_en),
    .rd_idx   (ent_rd_idx),
    .rd_addr  (ent_rd_addr),
    .rd_port  (ent_rd_port),
    .rd_owner (ent_rd_owner)
  );

  ctlf_id_map #(
    .MAX_PEERS (MAX_PEERS),
    .IW        (IW)
  ) u_id_map (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (map_rd_en),
    .rd_idx   (IW'(req.free_id)),
    .rd_slot  (map_rd_slot),
    .wr_en    (map_wr_en),
    .wr_idx   (map_wr_idx),
    .wr_slot  (map_wr_slot),
    .vld_set  (vld_set),
    .vld_clr  (vld_clr),
    .vld_idx  (vld_idx),
    .id_valid (id_valid)
  );

  // Table never holds more entries than ids
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_MAX)
    else $error("entry count above table depth");

  // Used ids and packed entries stay in step
  a_count_ids: assert property (@(posedge clk) disable iff (rst)
    $countones(id_valid) == 32'(count))
    else $error("used id count differs from entry count");

  // An accepted item always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted item dropped");

  // A free that moves an entry shrinks the table by one
  a_free_shrink: assert property (@(posedge clk) disable iff (rst)
    state == S_FMOVE |=> count == $past(count) - 1'b1)
    else $error("free did not shrink table");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state not one-hot");

endmodule
